// ===== rtl/core/cld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning package
// Shared widths, operation and register codes, and the transaction types
// exchanged between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package cld_pkg;

    // Field widths fixed by the interface.
    localparam int POS_W      = 32;
    localparam int SIZE_W     = 31;
    localparam int CNT_W      = 6;
    localparam int CELL_W     = 5;
    localparam int HEAD_W     = 17;
    localparam int PIDX_W     = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNTS_W   = 18;
    localparam int MODE_W     = 4;

    // Particle indexes wrap at this count.
    localparam int MAX_PARTICLES = 65536;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Empty chain marker (-1 in 17 bits).
    localparam logic [HEAD_W-1:0] EMPTY_HEAD = 17'h1FFFF;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FOLD   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNTS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_BITS   = 3'd7;

    // Axis codes used by the periodic fold.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [PIDX_W-1:0]        particle_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic                     is_free;
    } t_item;

    // Result transaction.
    typedef struct packed {
        logic signed [HEAD_W-1:0] prev_head;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic [CELL_W-1:0]        cell_z;
        logic                     fixed_flag;
    } t_result;

    // Result of every operation other than an insert.
    localparam t_result RESULT_NONE = '{
        prev_head:  EMPTY_HEAD,
        cell_x:     '0,
        cell_y:     '0,
        cell_z:     '0,
        fixed_flag: 1'b0
    };

    // Effective cell counts per axis, already limited to the grid.
    typedef struct packed {
        logic [CNT_W-1:0] cx;
        logic [CNT_W-1:0] cy;
        logic [CNT_W-1:0] cz;
    } t_counts;

    // Decoded configuration seen by the front and back end.
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [POS_W-1:0] origin_z;
        logic [SIZE_W-1:0]       size_x;
        logic [SIZE_W-1:0]       size_y;
        logic [SIZE_W-1:0]       size_z;
        t_counts                 counts;
        logic [2:0]              periodic;
    } t_cfg;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HEAD_W-1:0] pidx;
        logic [CNT_W-1:0]  cx;
        logic [CNT_W-1:0]  cy;
        logic [CNT_W-1:0]  cz;
        logic              fixed_flag;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/cell_list_binning_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning top level
// Builds a cell linked list: head table per cell, particle insert, clear
// and periodic fold, with a divider front end and a table back end.
// ----------------------------------------------------------------------------
// After reset the head table is swept to empty, one entry per cycle, over all
// MAX_CELLS_PER_AXIS cubed entries (32768 at the default), and busy stays high
// throughout. An insert keeps busy high while the three 32-step radix-2
// dividers run in parallel, one per axis, and until its command is pushed;
// its result strobes once the back end has read and rewritten the head entry.
// Clear and fold commands skip the dividers and run in the back end from the
// command queue: a clear sweeps the whole table, a fold copies each cell pair
// through one read state and two write states on each periodic axis. A full
// two-entry queue stalls the front end, which keeps busy high meanwhile.
// Every transaction returns exactly one result, in order, shown for a single
// cycle with o_strobe; the receiver must take it then, as it cannot stall.
// ----------------------------------------------------------------------------
module cell_list_binning_top #(
    parameter int MAX_CELLS_PER_AXIS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire cld_pkg::t_item                 i_item,
    output logic                                o_strobe,
    output cld_pkg::t_result                    o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [cld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [cld_pkg::POS_W-1:0]   r_origin_x;
    logic signed [cld_pkg::POS_W-1:0]   r_origin_y;
    logic signed [cld_pkg::POS_W-1:0]   r_origin_z;
    logic [cld_pkg::SIZE_W-1:0]         r_size_x;
    logic [cld_pkg::SIZE_W-1:0]         r_size_y;
    logic [cld_pkg::SIZE_W-1:0]         r_size_z;
    logic [cld_pkg::COUNTS_W-1:0]       r_cell_counts;
    logic [cld_pkg::MODE_W-1:0]         r_mode;

    cld_pkg::t_cfg                      w_cfg;
    cld_pkg::t_cmd                      w_push_cmd;
    cld_pkg::t_cmd                      w_pop_cmd;
    logic                               w_accept;
    logic                               w_front_busy;
    logic                               w_back_init;
    logic                               w_push;
    logic                               w_pop;
    logic                               w_full;
    logic                               w_empty;

    // Limit a configured count to 1..MAX_CELLS_PER_AXIS.
    function automatic logic [cld_pkg::CNT_W-1:0] eff_count(
        input logic [cld_pkg::CNT_W-1:0] raw
    );
        if (raw == '0) begin
            return cld_pkg::CNT_W'(1);
        end else if (raw > cld_pkg::CNT_W'(MAX_CELLS_PER_AXIS)) begin
            return cld_pkg::CNT_W'(MAX_CELLS_PER_AXIS);
        end else begin
            return raw;
        end
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_origin_z    <= '0;
            r_size_x      <= cld_pkg::SIZE_W'(65536);
            r_size_y      <= cld_pkg::SIZE_W'(65536);
            r_size_z      <= cld_pkg::SIZE_W'(65536);
            r_cell_counts <= cld_pkg::COUNTS_W'(33825);
            r_mode        <= cld_pkg::MODE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cld_pkg::CFG_ORIGIN_X:    r_origin_x    <= $signed(i_cfg_data);
                cld_pkg::CFG_ORIGIN_Y:    r_origin_y    <= $signed(i_cfg_data);
                cld_pkg::CFG_ORIGIN_Z:    r_origin_z    <= $signed(i_cfg_data);
                cld_pkg::CFG_CELL_SIZE_X: r_size_x      <= i_cfg_data[cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_SIZE_Y: r_size_y      <= i_cfg_data[cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_SIZE_Z: r_size_z      <= i_cfg_data[cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_COUNTS: r_cell_counts <= i_cfg_data[cld_pkg::COUNTS_W-1:0];
                cld_pkg::CFG_MODE_BITS:   r_mode        <= i_cfg_data[cld_pkg::MODE_W-1:0];
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Decoded configuration; a two-dimensional grid has a single z layer.
    always_comb begin
        w_cfg.origin_x  = r_origin_x;
        w_cfg.origin_y  = r_origin_y;
        w_cfg.origin_z  = r_origin_z;
        w_cfg.size_x    = r_size_x;
        w_cfg.size_y    = r_size_y;
        w_cfg.size_z    = r_size_z;
        w_cfg.counts.cx = eff_count(r_cell_counts[5:0]);
        w_cfg.counts.cy = eff_count(r_cell_counts[11:6]);
        w_cfg.counts.cz = r_mode[0] ? eff_count(r_cell_counts[17:12])
                                    : cld_pkg::CNT_W'(1);
        w_cfg.periodic  = r_mode[3:1];
    end

    // Command handshake.
    assign busy     = w_front_busy || w_back_init;
    assign w_accept = start && !busy;

    cld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_item),
        .i_cfg   (w_cfg),
        .i_full  (w_full),
        .o_busy  (w_front_busy),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    cld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_pop_cmd)
    );

    cld_back #(
        .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_empty (w_empty),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_init  (w_back_init),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low right after an accepted transaction");

    // The clearing pass after reset produces no result.
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_init |-> !o_strobe)
        else $error("result strobe during the reset clearing pass");

endmodule
`default_nettype wire

// ===== rtl/core/cld_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning radix-2 divider
// Unsigned restoring divider, one quotient bit per cycle, for a
// 32-bit dividend over a 31-bit divisor.
// ----------------------------------------------------------------------------
module cld_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [cld_pkg::POS_W-1:0]  i_dividend,
    input  wire logic [cld_pkg::SIZE_W-1:0] i_divisor,
    output logic                            o_busy,
    output logic [cld_pkg::POS_W-1:0]       o_quotient
);

    localparam int STEP_W = $clog2(cld_pkg::POS_W);

    logic [cld_pkg::POS_W-1:0]  r_quo;
    logic [cld_pkg::SIZE_W-1:0] r_rem;
    logic [cld_pkg::SIZE_W-1:0] r_div;
    logic [STEP_W-1:0]          r_cnt;
    logic                       r_busy;

    logic [cld_pkg::POS_W-1:0]  w_shift;
    logic [cld_pkg::POS_W:0]    w_trial;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign w_shift = {r_rem, r_quo[cld_pkg::POS_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_div};

    // Iteration control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[cld_pkg::POS_W]) begin
                r_rem <= w_trial[cld_pkg::SIZE_W-1:0];
            end else begin
                r_rem <= w_shift[cld_pkg::SIZE_W-1:0];
            end
            r_quo <= {r_quo[cld_pkg::POS_W-2:0], ~w_trial[cld_pkg::POS_W]};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(cld_pkg::POS_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/core/cld_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning front end
// Accepts transactions, bins insert positions with three parallel dividers,
// clamps the cell coordinates and pushes a command into the queue.
// ----------------------------------------------------------------------------
module cld_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire cld_pkg::t_item  i_item,
    input  wire cld_pkg::t_cfg   i_cfg,
    input  wire logic            i_full,
    output logic                 o_busy,
    output logic                 o_push,
    output cld_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    t_fstate                            r_state;
    logic [cld_pkg::OP_W-1:0]           r_op;
    logic [cld_pkg::HEAD_W-1:0]         r_pidx;
    logic                               r_fixed;

    logic [cld_pkg::POS_W:0]            w_diff_x, w_diff_y, w_diff_z;
    logic [cld_pkg::POS_W-1:0]          w_dvd_x, w_dvd_y, w_dvd_z;
    logic [cld_pkg::SIZE_W-1:0]         w_dsr_x, w_dsr_y, w_dsr_z;
    logic [cld_pkg::POS_W-1:0]          w_q_x, w_q_y, w_q_z;
    logic                               w_busy_x, w_busy_y, w_busy_z;
    logic                               w_div_start;

    // Limit a quotient to the last cell of its axis.
    function automatic logic [cld_pkg::CNT_W-1:0] clamp_q(
        input logic [cld_pkg::POS_W-1:0] q,
        input logic [cld_pkg::CNT_W-1:0] cnt
    );
        if (q >= cld_pkg::POS_W'(cnt)) begin
            return cnt - 1'b1;
        end else begin
            return q[cld_pkg::CNT_W-1:0];
        end
    endfunction

    // Offset from the domain corner; a position below the corner divides as zero.
    assign w_diff_x = {i_item.pos_x[cld_pkg::POS_W-1], i_item.pos_x}
                    - {i_cfg.origin_x[cld_pkg::POS_W-1], i_cfg.origin_x};
    assign w_diff_y = {i_item.pos_y[cld_pkg::POS_W-1], i_item.pos_y}
                    - {i_cfg.origin_y[cld_pkg::POS_W-1], i_cfg.origin_y};
    assign w_diff_z = {i_item.pos_z[cld_pkg::POS_W-1], i_item.pos_z}
                    - {i_cfg.origin_z[cld_pkg::POS_W-1], i_cfg.origin_z};

    assign w_dvd_x = w_diff_x[cld_pkg::POS_W] ? '0 : w_diff_x[cld_pkg::POS_W-1:0];
    assign w_dvd_y = w_diff_y[cld_pkg::POS_W] ? '0 : w_diff_y[cld_pkg::POS_W-1:0];
    assign w_dvd_z = w_diff_z[cld_pkg::POS_W] ? '0 : w_diff_z[cld_pkg::POS_W-1:0];

    // A zero cell size behaves as the smallest step.
    assign w_dsr_x = (i_cfg.size_x == '0) ? cld_pkg::SIZE_W'(1) : i_cfg.size_x;
    assign w_dsr_y = (i_cfg.size_y == '0) ? cld_pkg::SIZE_W'(1) : i_cfg.size_y;
    assign w_dsr_z = (i_cfg.size_z == '0) ? cld_pkg::SIZE_W'(1) : i_cfg.size_z;

    assign w_div_start = i_accept && (i_item.op == cld_pkg::OP_INSERT);

    // One divider per axis, all started together.
    cld_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_x),
        .i_divisor  (w_dsr_x),
        .o_busy     (w_busy_x),
        .o_quotient (w_q_x)
    );

    cld_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_y),
        .i_divisor  (w_dsr_y),
        .o_busy     (w_busy_y),
        .o_quotient (w_q_y)
    );

    cld_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_z),
        .i_divisor  (w_dsr_z),
        .o_busy     (w_busy_z),
        .o_quotient (w_q_z)
    );

    // Front state machine: accept, wait for the quotients, hand off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_accept) begin
                        r_op    <= i_item.op;
                        r_pidx  <= cld_pkg::HEAD_W'(
                                   32'(i_item.particle_index) % cld_pkg::MAX_PARTICLES);
                        r_fixed <= ~i_item.is_free;
                        if (i_item.op == cld_pkg::OP_INSERT) begin
                            r_state <= F_DIV;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    if (!(w_busy_x || w_busy_y || w_busy_z)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Command built from the held transaction and the settled quotients.
    always_comb begin
        o_cmd.op         = r_op;
        o_cmd.pidx       = r_pidx;
        o_cmd.cx         = clamp_q(w_q_x, i_cfg.counts.cx);
        o_cmd.cy         = clamp_q(w_q_y, i_cfg.counts.cy);
        o_cmd.cz         = clamp_q(w_q_z, i_cfg.counts.cz);
        o_cmd.fixed_flag = r_fixed;
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_busy = (r_state != F_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/cld_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cld_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cld_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output cld_pkg::t_cmd       o_cmd
);

    localparam int DEPTH = cld_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cld_pkg::t_cmd      r_entry [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd];

endmodule
`default_nettype wire

// ===== rtl/core/cld_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list binning back end
// Owns the head table memory and executes queued commands: insert
// read-modify-write, clearing sweep and periodic layer fold.
// ----------------------------------------------------------------------------
module cld_back #(
    parameter int MAX_CELLS_PER_AXIS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cld_pkg::t_cfg  i_cfg,
    input  wire logic           i_empty,
    input  wire cld_pkg::t_cmd  i_cmd,
    output logic                o_pop,
    output logic                o_init,
    output logic                o_strobe,
    output cld_pkg::t_result    o_result
);

    localparam int DEPTH = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = cld_pkg::CNT_W;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_INS_RD,
        B_INS_WR,
        B_FSEL,
        B_FRD1,
        B_FWR1,
        B_FWR0
    } t_bstate;

    t_bstate                    r_state;
    logic                       r_init;
    logic [AW-1:0]              r_ptr;
    logic [1:0]                 r_axis;
    logic [CW-1:0]              r_a;
    logic [CW-1:0]              r_b;
    cld_pkg::t_cmd              r_cmd;
    logic                       r_strobe;
    cld_pkg::t_result           r_result;

    logic [cld_pkg::HEAD_W-1:0] r_mem [DEPTH];
    logic [cld_pkg::HEAD_W-1:0] r_rdata;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [AW-1:0]              w_raddr;
    logic [cld_pkg::HEAD_W-1:0] w_wdata;
    logic [AW-1:0]              w_ins_addr;
    logic [CW-1:0]              w_cnt;
    logic [CW-1:0]              w_outer;
    logic [CW-1:0]              w_inner;
    logic                       w_per;
    logic                       w_axis_en;
    logic [CW-1:0]              w_rd_layer;
    logic [CW-1:0]              w_wr_layer;

    // Linear table address of cell (x, y, z).
    function automatic logic [AW-1:0] cell_addr(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input logic [CW-1:0] z
    );
        logic [AW-1:0] t;
        t = AW'(x) * AW'(MAX_CELLS_PER_AXIS) + AW'(y);
        return t * AW'(MAX_CELLS_PER_AXIS) + AW'(z);
    endfunction

    // Address of a layer cell on the axis being folded.
    function automatic logic [AW-1:0] fold_addr(
        input logic [1:0]    axis,
        input logic [CW-1:0] layer,
        input logic [CW-1:0] a,
        input logic [CW-1:0] b
    );
        case (axis)
            cld_pkg::AXIS_X: return cell_addr(layer, a, b);
            cld_pkg::AXIS_Y: return cell_addr(a, layer, b);
            default:         return cell_addr(a, b, layer);
        endcase
    endfunction

    // Loop bounds of the axis being folded.
    always_comb begin
        case (r_axis)
            cld_pkg::AXIS_X: begin
                w_cnt   = i_cfg.counts.cx;
                w_outer = i_cfg.counts.cy;
                w_inner = i_cfg.counts.cz;
                w_per   = i_cfg.periodic[0];
            end
            cld_pkg::AXIS_Y: begin
                w_cnt   = i_cfg.counts.cy;
                w_outer = i_cfg.counts.cx;
                w_inner = i_cfg.counts.cz;
                w_per   = i_cfg.periodic[1];
            end
            cld_pkg::AXIS_Z: begin
                w_cnt   = i_cfg.counts.cz;
                w_outer = i_cfg.counts.cx;
                w_inner = i_cfg.counts.cy;
                w_per   = i_cfg.periodic[2];
            end
            default: begin
                w_cnt   = '0;
                w_outer = '0;
                w_inner = '0;
                w_per   = 1'b0;
            end
        endcase
    end

    // An axis with fewer than two cells is not folded.
    assign w_axis_en  = w_per && (w_cnt >= CW'(2));
    assign w_rd_layer = (r_state == B_FRD1) ? CW'(1) : '0;
    assign w_wr_layer = (r_state == B_FWR1) ? w_cnt - CW'(1) : w_cnt - CW'(2);
    assign w_ins_addr = cell_addr(r_cmd.cx, r_cmd.cy, r_cmd.cz);

    // Memory port control per state.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_ins_addr;
        w_wdata = r_cmd.pidx;
        w_raddr = w_ins_addr;
        case (r_state)
            B_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = cld_pkg::EMPTY_HEAD;
            end
            B_INS_WR: begin
                w_we    = 1'b1;
            end
            B_FRD1: begin
                w_raddr = fold_addr(r_axis, w_rd_layer, r_a, r_b);
            end
            B_FWR1, B_FWR0: begin
                w_we    = 1'b1;
                w_waddr = fold_addr(r_axis, w_wr_layer, r_a, r_b);
                w_wdata = r_rdata;
                w_raddr = fold_addr(r_axis, w_rd_layer, r_a, r_b);
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    // Head table with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Command sequencer with registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLR;
            r_init   <= 1'b1;
            r_ptr    <= '0;
            r_axis   <= cld_pkg::AXIS_X;
            r_a      <= '0;
            r_b      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                B_CLR: begin
                    if (r_ptr == AW'(DEPTH - 1)) begin
                        r_state <= B_IDLE;
                        r_init  <= 1'b0;
                        if (!r_init) begin
                            r_strobe <= 1'b1;
                            r_result <= cld_pkg::RESULT_NONE;
                        end
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            cld_pkg::OP_INSERT: begin
                                r_state <= B_INS_RD;
                            end
                            cld_pkg::OP_CLEAR: begin
                                r_ptr   <= '0;
                                r_state <= B_CLR;
                            end
                            cld_pkg::OP_FOLD: begin
                                r_axis  <= cld_pkg::AXIS_X;
                                r_state <= B_FSEL;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_result <= cld_pkg::RESULT_NONE;
                            end
                        endcase
                    end
                end
                B_INS_RD: begin
                    r_state <= B_INS_WR;
                end
                B_INS_WR: begin
                    r_state             <= B_IDLE;
                    r_strobe            <= 1'b1;
                    r_result.prev_head  <= $signed(r_rdata);
                    r_result.cell_x     <= r_cmd.cx[cld_pkg::CELL_W-1:0];
                    r_result.cell_y     <= r_cmd.cy[cld_pkg::CELL_W-1:0];
                    r_result.cell_z     <= r_cmd.cz[cld_pkg::CELL_W-1:0];
                    r_result.fixed_flag <= r_cmd.fixed_flag;
                end
                B_FSEL: begin
                    if (w_axis_en) begin
                        r_a     <= '0;
                        r_b     <= '0;
                        r_state <= B_FRD1;
                    end else if (r_axis == cld_pkg::AXIS_Z) begin
                        r_state  <= B_IDLE;
                        r_strobe <= 1'b1;
                        r_result <= cld_pkg::RESULT_NONE;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                B_FRD1: begin
                    r_state <= B_FWR1;
                end
                B_FWR1: begin
                    r_state <= B_FWR0;
                end
                B_FWR0: begin
                    // Step to the next cell of the layer, then the next axis.
                    if (r_b != w_inner - CW'(1)) begin
                        r_b     <= r_b + 1'b1;
                        r_state <= B_FRD1;
                    end else if (r_a != w_outer - CW'(1)) begin
                        r_b     <= '0;
                        r_a     <= r_a + 1'b1;
                        r_state <= B_FRD1;
                    end else if (r_axis == cld_pkg::AXIS_Z) begin
                        r_state  <= B_IDLE;
                        r_strobe <= 1'b1;
                        r_result <= cld_pkg::RESULT_NONE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= B_FSEL;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_init   = r_init;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== test/cell_list_binning_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell list binning testbench
// Drives clear, insert, fold and spare-code transactions into the binning block under
// directed and random configurations. A behavioral copy of the head table
// computes the result of every accepted transaction, and each strobed result
// is compared field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module cell_list_binning_top_tb;

    localparam int GRID        = 32;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 55;
    localparam logic [cld_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    // Block ports.
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    cld_pkg::t_item                 i_item;
    logic                           o_strobe;
    cld_pkg::t_result               o_result;
    logic                           i_cfg_we;
    logic [cld_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cld_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the head table and of the configuration registers.
    logic [cld_pkg::HEAD_W-1:0]       heads [GRID*GRID*GRID];
    logic signed [cld_pkg::POS_W-1:0] org [3];
    logic [cld_pkg::SIZE_W-1:0]       csize [3];
    logic [cld_pkg::COUNTS_W-1:0]     counts_reg;
    logic [cld_pkg::MODE_W-1:0]       mode_reg;

    // Results still owed by the block, oldest first.
    cld_pkg::t_result expected_results [$];

    int  errors;
    int  cycle_count;
    int  clears_left;
    bit  steady;
    bit  had_clear;
    bit  had_fold;

    cell_list_binning_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Effective number of cells along one axis.
    function automatic int unsigned axis_cells(int axis);
        int unsigned c;
        if (axis == 2 && !mode_reg[0]) return 1;
        c = 32'(counts_reg[cld_pkg::CNT_W*axis +: cld_pkg::CNT_W]);
        if (c == 0) c = 1;
        if (c > GRID) c = GRID;
        return c;
    endfunction

    function automatic int unsigned slot_of(int unsigned x, int unsigned y, int unsigned z);
        return (x * GRID + y) * GRID + z;
    endfunction

    // Floor of (pos - origin) / size, clamped to the axis.
    function automatic int unsigned bin_coord(int axis, logic signed [cld_pkg::POS_W-1:0] pos);
        longint            diff;
        longint unsigned   q;
        longint unsigned   s;
        diff = longint'(pos) - longint'(org[axis]);
        if (diff < 0) return 0;
        s = (csize[axis] == 0) ? 1 : csize[axis];
        q = longint'(diff) / s;
        if (q >= axis_cells(axis)) q = axis_cells(axis) - 1;
        return int'(q);
    endfunction

    // Periodic fold: the first two layers are copied onto the last two.
    function automatic void fold_heads();
        int unsigned cx, cy, cz;
        cx = axis_cells(0);
        cy = axis_cells(1);
        cz = axis_cells(2);
        if (mode_reg[1] && cx >= 2)
            for (int a = 0; a < cy; a++)
                for (int b = 0; b < cz; b++) begin
                    heads[slot_of(cx - 1, a, b)] = heads[slot_of(1, a, b)];
                    heads[slot_of(cx - 2, a, b)] = heads[slot_of(0, a, b)];
                end
        if (mode_reg[2] && cy >= 2)
            for (int a = 0; a < cx; a++)
                for (int b = 0; b < cz; b++) begin
                    heads[slot_of(a, cy - 1, b)] = heads[slot_of(a, 1, b)];
                    heads[slot_of(a, cy - 2, b)] = heads[slot_of(a, 0, b)];
                end
        if (mode_reg[3] && cz >= 2)
            for (int a = 0; a < cx; a++)
                for (int b = 0; b < cy; b++) begin
                    heads[slot_of(a, b, cz - 1)] = heads[slot_of(a, b, 1)];
                    heads[slot_of(a, b, cz - 2)] = heads[slot_of(a, b, 0)];
                end
    endfunction

    // Applies one transaction to the shadow table and returns its result.
    function automatic cld_pkg::t_result predict_binning(cld_pkg::t_item it);
        cld_pkg::t_result r;
        int unsigned      x, y, z, s;
        r = cld_pkg::RESULT_NONE;
        case (it.op)
            cld_pkg::OP_CLEAR: begin
                foreach (heads[n]) heads[n] = cld_pkg::EMPTY_HEAD;
            end
            cld_pkg::OP_FOLD: begin
                fold_heads();
            end
            cld_pkg::OP_INSERT: begin
                x = bin_coord(0, it.pos_x);
                y = bin_coord(1, it.pos_y);
                z = mode_reg[0] ? bin_coord(2, it.pos_z) : 0;
                s = slot_of(x, y, z);
                r.prev_head  = heads[s];
                heads[s]     = {1'b0, it.particle_index};
                r.cell_x     = x[cld_pkg::CELL_W-1:0];
                r.cell_y     = y[cld_pkg::CELL_W-1:0];
                r.cell_z     = z[cld_pkg::CELL_W-1:0];
                r.fixed_flag = ~it.is_free;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin : check_results
        cld_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("unexpected result %h at cycle %0d", o_result, cycle_count);
            end else begin
                want = expected_results.pop_front();
                if (o_result.prev_head !== want.prev_head ||
                    o_result.cell_x !== want.cell_x ||
                    o_result.cell_y !== want.cell_y ||
                    o_result.cell_z !== want.cell_z ||
                    o_result.fixed_flag !== want.fixed_flag) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected head %h xyz %0d/%0d/%0d fixed %b",
                                 want.prev_head, want.cell_x, want.cell_y,
                                 want.cell_z, want.fixed_flag);
                        $display("  got      head %h xyz %0d/%0d/%0d fixed %b",
                                 o_result.prev_head, o_result.cell_x, o_result.cell_y,
                                 o_result.cell_z, o_result.fixed_flag);
                    end
                end
            end
        end
    end

    // Sends one transaction; unless steady is set, start drops low in random cycles until it is taken.
    task automatic send_item(input cld_pkg::t_item it);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            start  <= steady || ($urandom_range(0, 99) >= 27);
            i_item <= it;
            @(posedge i_clk);
            taken = start && !busy;
        end
        expected_results = {expected_results, predict_binning(it)};
        if (it.op == cld_pkg::OP_CLEAR) had_clear = 1'b1;
        if (it.op == cld_pkg::OP_FOLD) had_fold = 1'b1;
    endtask

    // Waits until every result is in and background table work has ended.
    task automatic drain();
        int settle;
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        if (had_clear) settle = GRID * GRID * GRID + 100;
        else if (had_fold) settle = 9 * GRID * GRID + 100;
        else settle = 40;
        repeat (settle) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        had_clear = 1'b0;
        had_fold  = 1'b0;
    endtask

    // Writes all eight registers, in index order, and mirrors them.
    task automatic write_regs(input logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= cld_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            case (cld_pkg::CFG_IDX_W'(i))
                cld_pkg::CFG_ORIGIN_X:    org[0] = vals[i];
                cld_pkg::CFG_ORIGIN_Y:    org[1] = vals[i];
                cld_pkg::CFG_ORIGIN_Z:    org[2] = vals[i];
                cld_pkg::CFG_CELL_SIZE_X: csize[0] = vals[i][cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_SIZE_Y: csize[1] = vals[i][cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_SIZE_Z: csize[2] = vals[i][cld_pkg::SIZE_W-1:0];
                cld_pkg::CFG_CELL_COUNTS: counts_reg = vals[i][cld_pkg::COUNTS_W-1:0];
                cld_pkg::CFG_MODE_BITS:   mode_reg = vals[i][cld_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic cld_pkg::t_item make_insert(
        logic [cld_pkg::PIDX_W-1:0] pidx,
        logic [31:0]                px,
        logic [31:0]                py,
        logic [31:0]                pz,
        logic                       free
    );
        cld_pkg::t_item it;
        it.op             = cld_pkg::OP_INSERT;
        it.particle_index = pidx;
        it.pos_x          = px;
        it.pos_y          = py;
        it.pos_z          = pz;
        it.is_free        = free;
        return it;
    endfunction

    // Non-insert transaction; the other fields carry noise.
    function automatic cld_pkg::t_item make_op(logic [cld_pkg::OP_W-1:0] op);
        cld_pkg::t_item it;
        it    = make_insert(16'($urandom), $urandom, $urandom, $urandom,
                            1'($urandom_range(0, 1)));
        it.op = op;
        return it;
    endfunction

    // Position that mostly lands inside the grid, often on a cell boundary.
    function automatic logic [31:0] pick_pos(int axis);
        longint s;
        longint off;
        int     roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return $urandom;
        s = (csize[axis] == 0) ? 1 : csize[axis];
        if (roll < 35)
            off = longint'($urandom_range(0, axis_cells(axis))) * s - $urandom_range(0, 1);
        else
            off = longint'({$urandom, $urandom} % (longint'(axis_cells(axis) + 1) * s));
        return 32'(longint'(org[axis]) + off);
    endfunction

    // Defaults after reset: field extremes, boundaries, every operation.
    task automatic test_default_config();
        send_item(make_insert(16'h0000, 32'h0, 32'h0, 32'h0, 1'b1));
        send_item(make_insert(16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0));
        send_item(make_insert(16'h1234, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
        send_item(make_insert(16'h0007, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_item(make_insert(16'h0008, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_FFFF, 1'b1));
        send_item(make_insert(16'h0009, 32'h0001_0000, 32'h0000_FFFF, 32'h0002_0000, 1'b0));
        send_item(make_op(OP_SPARE));
        send_item(make_op(cld_pkg::OP_FOLD));
        send_item(make_insert(16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        send_item(make_op(cld_pkg::OP_CLEAR));
        send_item(make_insert(16'h0003, 32'h0, 32'h0, 32'h0, 1'b1));
        drain();
    endtask

    // Register extremes: zero and maximum sizes, counts of 0 and 63.
    task automatic test_register_extremes();
        logic [31:0] vals [8];
        vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0,
                 32'(0 | (63 << 6) | (2 << 12)), 32'hF};
        write_regs(vals);
        send_item(make_insert(16'h0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 1'b0));
        send_item(make_insert(16'h0002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
        send_item(make_insert(16'h0003, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0));
        send_item(make_op(cld_pkg::OP_FOLD));
        send_item(make_insert(16'h0004, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 1'b1));
        drain();
    endtask

    // Two-dimensional grid with periodic x and y, folded onto itself.
    task automatic test_fold_2d();
        logic [31:0] vals [8];
        vals = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                 32'(4 | (3 << 6)), 32'h6};
        write_regs(vals);
        send_item(make_insert(16'd10, 32'h0_8000, 32'h0_8000, 32'h5_0000, 1'b1));
        send_item(make_insert(16'd11, 32'h1_8000, 32'h1_8000, 32'h0, 1'b1));
        send_item(make_op(cld_pkg::OP_FOLD));
        send_item(make_insert(16'd12, 32'h2_8000, 32'h0_8000, 32'h0, 1'b0));
        send_item(make_insert(16'd13, 32'h3_8000, 32'h1_8000, 32'h0, 1'b1));
        send_item(make_insert(16'd14, 32'h3_8000, 32'h2_8000, 32'h0, 1'b0));
        drain();
    endtask

    // Random configurations, each followed by a burst of random traffic.
    task automatic test_random_traffic();
        logic [31:0]    vals [8];
        int             roll;
        cld_pkg::t_item it;
        for (int p = 0; p < PHASES; p++) begin
            for (int a = 0; a < 3; a++) begin
                vals[a] = ($urandom_range(0, 99) < 70) ?
                          32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000 : $urandom;
                roll = $urandom_range(0, 99);
                if (roll < 60) vals[3 + a] = $urandom_range(32'h8000, 32'h3_0000);
                else if (roll < 85) vals[3 + a] = $urandom;
                else if (roll < 95) vals[3 + a] = $urandom_range(0, 3);
                else vals[3 + a] = 32'h7FFF_FFFF;
            end
            vals[6] = 0;
            for (int a = 0; a < 3; a++)
                vals[6][6*a +: 6] = 6'(($urandom_range(0, 99) < 75) ?
                                       $urandom_range(0, 5) : $urandom_range(0, 63));
            vals[6][31:18] = 14'($urandom);
            vals[7] = $urandom;
            write_regs(vals);
            // One phase runs back to back with no idle cycles.
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 199);
                if (roll < 2 && clears_left > 0) begin
                    clears_left = clears_left - 1;
                    it = make_op(cld_pkg::OP_CLEAR);
                end else if (roll < 16) begin
                    it = make_op(cld_pkg::OP_FOLD);
                end else if (roll < 22) begin
                    it = make_op(OP_SPARE);
                end else begin
                    it = make_insert(16'($urandom_range(0, 65535)), pick_pos(0), pick_pos(1),
                                     pick_pos(2), 1'($urandom_range(0, 1)));
                end
                send_item(it);
            end
            drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        errors      = 0;
        cycle_count = 0;
        clears_left = 3;
        steady      = 1'b0;
        had_clear   = 1'b0;
        had_fold    = 1'b0;
        foreach (heads[n]) heads[n] = cld_pkg::EMPTY_HEAD;
        for (int a = 0; a < 3; a++) begin
            org[a]   = '0;
            csize[a] = 31'd65536;
        end
        counts_reg = 18'd33825;
        mode_reg   = 4'd1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The table sweep after reset keeps busy high.
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        test_default_config();
        test_register_extremes();
        test_fold_2d();
        test_random_traffic();

        if (expected_results.size() != 0) begin
            $display("%0d results never arrived", expected_results.size());
            errors = errors + expected_results.size();
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cld_pkg.sv
rtl/core/cld_div.sv
rtl/core/cld_front.sv
rtl/core/cld_queue.sv
rtl/core/cld_back.sv
rtl/core/cell_list_binning_top.sv
test/cell_list_binning_top_tb.sv
